/* rtl/core/rbo_pkg.sv */
`timescale 1ns / 1ps
// Shared widths, stream layout and the stage-enable bundle for the ray versus box test.
// No dependencies; every other file in rtl/core imports this package.
package rbo_pkg;

    // Coordinate and derived widths; coordinates are signed Q16.16.
    localparam int COORD_W  = 32;
    localparam int EXT_W    = COORD_W - 1;
    localparam int DIFF_W   = COORD_W + 1;
    localparam int PROD_W   = COORD_W + DIFF_W;
    localparam int BPROD_W  = EXT_W + COORD_W;
    localparam int BSUM_W   = BPROD_W + 1;
    localparam int CROSS_W  = PROD_W + 1;
    localparam int CMP_W    = CROSS_W + 1;

    // Stream widths, padded to whole bytes.
    localparam int S_FIELD_BITS = 9 * COORD_W + 3 * EXT_W;
    localparam int S_TDATA_W    = ((S_FIELD_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W    = 8;

    // Load enables for the stages kept inside the per-axis units.
    typedef struct packed {
        logic s2;
        logic s3;
    } pipe_en_t;

endpackage

/* rtl/core/rbo_face_check.sv */
`timescale 1ns / 1ps
// Slab test along one box face axis, registered over stages two and three.
// Depends on rbo_pkg for widths and the stage-enable bundle.
module rbo_face_check
    import rbo_pkg::*;
(
    input  logic                      aclk,
    input  pipe_en_t                  en,
    input  logic signed [DIFF_W-1:0]  diff,
    input  logic signed [COORD_W-1:0] dir,
    input  logic        [EXT_W-1:0]   ext,
    output logic                      sep
);

    logic [DIFF_W-1:0] diff_mag;
    logic              sep_s2_next;
    logic              sep_s2_reg;
    logic              sep_s3_reg;

    // The origin lies outside the slab and the ray does not head back into it.
    always_comb begin
        diff_mag    = diff[DIFF_W-1] ? (~diff + DIFF_W'(1)) : diff;
        sep_s2_next = (diff_mag > DIFF_W'(ext)) &&
                      ((dir == '0) || (diff[DIFF_W-1] == dir[COORD_W-1]));
    end

    // Carry the verdict alongside the cross-axis results.
    always_ff @(posedge aclk) begin
        if (en.s2) begin
            sep_s2_reg <= sep_s2_next;
        end
        if (en.s3) begin
            sep_s3_reg <= sep_s2_reg;
        end
    end

    assign sep = sep_s3_reg;

endmodule

/* rtl/core/rbo_cross_axis.sv */
`timescale 1ns / 1ps
// One cross-product axis: products in stage two, difference and bound in stage three,
// and the comparison offered to stage four. Depends on rbo_pkg.
module rbo_cross_axis
    import rbo_pkg::*;
(
    input  logic                      aclk,
    input  pipe_en_t                  en,
    input  logic signed [COORD_W-1:0] da,
    input  logic signed [COORD_W-1:0] db,
    input  logic        [COORD_W-1:0] da_mag,
    input  logic        [COORD_W-1:0] db_mag,
    input  logic signed [DIFF_W-1:0]  ua,
    input  logic signed [DIFF_W-1:0]  ub,
    input  logic        [EXT_W-1:0]   ea,
    input  logic        [EXT_W-1:0]   eb,
    output logic                      sep
);

    logic signed [PROD_W-1:0]  p_reg;
    logic signed [PROD_W-1:0]  q_reg;
    logic        [BPROD_W-1:0] ba_reg;
    logic        [BPROD_W-1:0] bb_reg;
    logic signed [CROSS_W-1:0] f_next;
    logic signed [CROSS_W-1:0] f_reg;
    logic        [BSUM_W-1:0]  bound_next;
    logic        [BSUM_W-1:0]  bound_reg;
    logic signed [CMP_W-1:0]   f_cmp;
    logic signed [CMP_W-1:0]   bound_cmp;

    // Stage two: the two cross terms and the two projected radius terms.
    always_ff @(posedge aclk) begin
        if (en.s2) begin
            p_reg  <= PROD_W'(da) * PROD_W'(ub);
            q_reg  <= PROD_W'(db) * PROD_W'(ua);
            ba_reg <= BPROD_W'(ea) * BPROD_W'(db_mag);
            bb_reg <= BPROD_W'(eb) * BPROD_W'(da_mag);
        end
    end

    // Stage three: signed cross component and the box radius on this axis.
    always_comb begin
        f_next     = CROSS_W'(p_reg) - CROSS_W'(q_reg);
        bound_next = BSUM_W'(ba_reg) + BSUM_W'(bb_reg);
    end

    always_ff @(posedge aclk) begin
        if (en.s3) begin
            f_reg     <= f_next;
            bound_reg <= bound_next;
        end
    end

    // Separates when the magnitude of the component strictly exceeds the radius.
    always_comb begin
        f_cmp     = CMP_W'(f_reg);
        bound_cmp = $signed({{(CMP_W - BSUM_W){1'b0}}, bound_reg});
        sep       = (f_cmp > bound_cmp) || (f_cmp < -bound_cmp);
    end

endmodule

/* rtl/core/ray_box_overlap_test.sv */
`timescale 1ns / 1ps
// Ray versus axis-aligned box test: four register stages, one beat per cycle sustained
// while the result side accepts (m_tready high). Stage one forms the offsets, stage two
// the products, stage three the cross components and radii, and stage four holds the
// result. Each stage loads whenever it is empty or its successor moves, so bubbles close
// up under back-pressure. Synchronous active-low reset empties the pipeline; payload
// registers are not reset. Depends on rbo_pkg and the axis units.
module ray_box_overlap_test
    import rbo_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // Input beat.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, box_center_x, box_center_y,
    // box_center_z (32 bits each), half_extent_x, half_extent_y, half_extent_z (31 bits each)
    input  logic [S_TDATA_W-1:0] s_tdata,
    // Result beat.
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // hit (bit 0), zero padding above
    output logic [M_TDATA_W-1:0] m_tdata
);

    logic signed [COORD_W-1:0] origin_x, origin_y, origin_z;
    logic signed [COORD_W-1:0] dir_x, dir_y, dir_z;
    logic signed [COORD_W-1:0] box_center_x, box_center_y, box_center_z;
    logic        [EXT_W-1:0]   half_extent_x, half_extent_y, half_extent_z;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic en1, en2, en3, en4;
    pipe_en_t en;

    logic signed [DIFF_W-1:0]  sx_reg, sy_reg, sz_reg;
    logic signed [COORD_W-1:0] dx_reg, dy_reg, dz_reg;
    logic        [COORD_W-1:0] mx_reg, my_reg, mz_reg;
    logic        [EXT_W-1:0]   ex_reg, ey_reg, ez_reg;

    logic face_x, face_y, face_z;
    logic cross_x, cross_y, cross_z;
    logic hit_next, hit_reg;

    // Unpack the input beat.
    assign origin_x      = s_tdata[31:0];
    assign origin_y      = s_tdata[63:32];
    assign origin_z      = s_tdata[95:64];
    assign dir_x         = s_tdata[127:96];
    assign dir_y         = s_tdata[159:128];
    assign dir_z         = s_tdata[191:160];
    assign box_center_x  = s_tdata[223:192];
    assign box_center_y  = s_tdata[255:224];
    assign box_center_z  = s_tdata[287:256];
    assign half_extent_x = s_tdata[318:288];
    assign half_extent_y = s_tdata[349:319];
    assign half_extent_z = s_tdata[380:350];

    // A stage loads when it is empty or its contents move on.
    assign en4      = !v4_reg || m_tready;
    assign en3      = !v3_reg || en4;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign en.s2    = en2;
    assign en.s3    = en3;
    assign s_tready = en1;

    // Valid bits travel with the data.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (en1) begin
                v1_reg <= s_tvalid;
            end
            if (en2) begin
                v2_reg <= v1_reg;
            end
            if (en3) begin
                v3_reg <= v2_reg;
            end
            if (en4) begin
                v4_reg <= v3_reg;
            end
        end
    end

    // Stage one: origin relative to the box centre, direction magnitudes.
    always_ff @(posedge aclk) begin
        if (en1) begin
            sx_reg <= DIFF_W'(origin_x) - DIFF_W'(box_center_x);
            sy_reg <= DIFF_W'(origin_y) - DIFF_W'(box_center_y);
            sz_reg <= DIFF_W'(origin_z) - DIFF_W'(box_center_z);
            dx_reg <= dir_x;
            dy_reg <= dir_y;
            dz_reg <= dir_z;
            mx_reg <= dir_x[COORD_W-1] ? (~dir_x + COORD_W'(1)) : dir_x;
            my_reg <= dir_y[COORD_W-1] ? (~dir_y + COORD_W'(1)) : dir_y;
            mz_reg <= dir_z[COORD_W-1] ? (~dir_z + COORD_W'(1)) : dir_z;
            ex_reg <= half_extent_x;
            ey_reg <= half_extent_y;
            ez_reg <= half_extent_z;
        end
    end

    // Face slab tests.
    rbo_face_check u_face_x (
        .aclk (aclk), .en (en), .diff (sx_reg), .dir (dx_reg), .ext (ex_reg),
        .sep  (face_x)
    );

    rbo_face_check u_face_y (
        .aclk (aclk), .en (en), .diff (sy_reg), .dir (dy_reg), .ext (ey_reg),
        .sep  (face_y)
    );

    rbo_face_check u_face_z (
        .aclk (aclk), .en (en), .diff (sz_reg), .dir (dz_reg), .ext (ez_reg),
        .sep  (face_z)
    );

    // Cross-product axis tests: x, y and z components of dir cross offset.
    rbo_cross_axis u_cross_x (
        .aclk   (aclk),   .en     (en),
        .da     (dy_reg), .db     (dz_reg), .da_mag (my_reg), .db_mag (mz_reg),
        .ua     (sy_reg), .ub     (sz_reg), .ea     (ey_reg), .eb     (ez_reg),
        .sep    (cross_x)
    );

    rbo_cross_axis u_cross_y (
        .aclk   (aclk),   .en     (en),
        .da     (dz_reg), .db     (dx_reg), .da_mag (mz_reg), .db_mag (mx_reg),
        .ua     (sz_reg), .ub     (sx_reg), .ea     (ez_reg), .eb     (ex_reg),
        .sep    (cross_y)
    );

    rbo_cross_axis u_cross_z (
        .aclk   (aclk),   .en     (en),
        .da     (dx_reg), .db     (dy_reg), .da_mag (mx_reg), .db_mag (my_reg),
        .ua     (sx_reg), .ub     (sy_reg), .ea     (ex_reg), .eb     (ey_reg),
        .sep    (cross_z)
    );

    // Stage four: a hit when no axis separates.
    assign hit_next = !(face_x || face_y || face_z || cross_x || cross_y || cross_z);

    always_ff @(posedge aclk) begin
        if (en4) begin
            hit_reg <= hit_next;
        end
    end

    assign m_tvalid = v4_reg;
    assign m_tdata  = {{(M_TDATA_W - 1){1'b0}}, hit_reg};

endmodule
